FILE: hw/rtl/spq_pkg.sv
// spq_pkg: shared constants for the stable priority queue
// stream widths, field widths, command and status codes; no dependencies

package spq_pkg;

    localparam int DEF_CAPACITY      = 16;
    localparam int DEF_PRIORITY_BITS = 8;

    localparam int VALUE_W    = 32;
    localparam int IN_PRIO_W  = 8;
    localparam int OUT_PRIO_W = 8;
    localparam int STATUS_W   = 2;
    localparam int FILL_W     = 5;

    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 48;

    localparam logic CMD_ENQUEUE = 1'b0;
    localparam logic CMD_DEQUEUE = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd2;

endpackage

FILE: hw/rtl/stable_priority_queue_top.sv
// stable_priority_queue_top: sorted priority queue kept in a circular buffer memory
// insertion walks from the tail one entry at a time, reading and then comparing each one; depends on spq_pkg
// overflow and underflow skip the memory; dequeue reads the head entry; enqueue reads and compares each entry moved
// throughput: one command at a time, next accepted once the result is loaded into o_m_tdata
// the single memory read port and the compare-and-move loop set the enqueue time
// reset: synchronous active low, empties the queue; memory contents are not cleared

module stable_priority_queue_top #(
    parameter int CAPACITY      = spq_pkg::DEF_CAPACITY,
    parameter int PRIORITY_BITS = spq_pkg::DEF_PRIORITY_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    // cmd[0], item_value[32:1], item_priority[40:33], zero pad
    input  logic [spq_pkg::S_TDATA_W-1:0] i_s_tdata,
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    // status[1:0], out_value[33:2], out_priority[41:34], fill_level[46:42], zero pad
    output logic [spq_pkg::M_TDATA_W-1:0] o_m_tdata
);

    localparam int AW  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW  = $clog2(CAPACITY + 1);
    localparam int VW  = spq_pkg::VALUE_W;
    localparam int PB  = PRIORITY_BITS;
    localparam int EW  = VW + PB;
    localparam logic [AW:0] CAP_W  = (AW + 1)'(CAPACITY);
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_INS_RD  = 3'd1;
    localparam logic [2:0] S_INS_CMP = 3'd2;
    localparam logic [2:0] S_DEQ     = 3'd3;
    localparam logic [2:0] S_EMIT    = 3'd4;

    function automatic logic [AW-1:0] f_wrap_add(input logic [AW-1:0] a,
                                                 input logic [AW-1:0] b);
        logic [AW:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= CAP_W) begin
            s = s - CAP_W;
        end
        return s[AW-1:0];
    endfunction

    logic [EW-1:0] r_mem [CAPACITY];
    logic [EW-1:0] r_rd_data;

    logic [2:0]    r_state, n_state;
    logic [AW-1:0] r_head, n_head;
    logic [CW-1:0] r_count, n_count;
    logic [AW-1:0] r_pos, n_pos;
    logic [VW-1:0] r_new_value, n_new_value;
    logic [PB-1:0] r_new_prio, n_new_prio;

    logic [spq_pkg::STATUS_W-1:0] r_res_status, n_res_status;
    logic [VW-1:0]                r_res_value, n_res_value;
    logic [PB-1:0]                r_res_prio, n_res_prio;

    logic                          r_out_valid, n_out_valid;
    logic [spq_pkg::M_TDATA_W-1:0] r_out_data, n_out_data;

    logic [AW-1:0] w_rd_log;
    logic [AW-1:0] w_rd_addr;
    logic [AW-1:0] w_wr_addr;
    logic          w_wr_en;
    logic [EW-1:0] w_wr_data;

    logic          w_in_cmd;
    logic [VW-1:0] w_in_value;
    logic [PB-1:0] w_in_prio;
    logic [PB+spq_pkg::IN_PRIO_W-1:0]  w_in_prio_ext;
    logic [PB+spq_pkg::OUT_PRIO_W-1:0] w_out_prio_ext;
    logic [CW+spq_pkg::FILL_W-1:0]     w_fill_ext;
    logic [PB-1:0] w_rd_prio;
    logic          w_accept;
    logic          w_out_free;

    assign w_in_cmd      = i_s_tdata[0];
    assign w_in_value    = i_s_tdata[VW:1];
    assign w_in_prio_ext = {{PB{1'b0}}, i_s_tdata[VW+spq_pkg::IN_PRIO_W:VW+1]};
    assign w_in_prio     = w_in_prio_ext[PB-1:0];
    assign w_rd_prio     = r_rd_data[PB-1:0];

    assign o_s_tready = (r_state == S_IDLE);
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_out_free = !r_out_valid || i_m_tready;

    assign w_rd_log  = (r_state == S_INS_RD) ? (r_pos - AW'(1)) : '0;
    assign w_rd_addr = f_wrap_add(r_head, w_rd_log);
    assign w_wr_addr = f_wrap_add(r_head, r_pos);

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
        r_rd_data <= r_mem[w_rd_addr];
    end

    always_comb begin
        n_state      = r_state;
        n_head       = r_head;
        n_count      = r_count;
        n_pos        = r_pos;
        n_new_value  = r_new_value;
        n_new_prio   = r_new_prio;
        n_res_status = r_res_status;
        n_res_value  = r_res_value;
        n_res_prio   = r_res_prio;
        w_wr_en      = 1'b0;
        w_wr_data    = {r_new_value, r_new_prio};

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_new_value = w_in_value;
                    n_new_prio  = w_in_prio;
                    n_res_value = '0;
                    n_res_prio  = '0;
                    if (w_in_cmd == spq_pkg::CMD_ENQUEUE) begin
                        if (r_count >= CAP_C) begin
                            n_res_status = spq_pkg::ST_OVERFLOW;
                            n_state      = S_EMIT;
                        end else begin
                            n_pos   = r_count[AW-1:0];
                            n_state = S_INS_RD;
                        end
                    end else begin
                        if (r_count == '0) begin
                            n_res_status = spq_pkg::ST_UNDERFLOW;
                            n_state      = S_EMIT;
                        end else begin
                            n_state = S_DEQ;
                        end
                    end
                end
            end
            S_INS_RD: begin
                if (r_pos == '0) begin
                    w_wr_en      = 1'b1;
                    n_count      = r_count + CW'(1);
                    n_res_status = spq_pkg::ST_OK;
                    n_state      = S_EMIT;
                end else begin
                    n_state = S_INS_CMP;
                end
            end
            S_INS_CMP: begin
                w_wr_en = 1'b1;
                if (w_rd_prio <= r_new_prio) begin
                    n_count      = r_count + CW'(1);
                    n_res_status = spq_pkg::ST_OK;
                    n_state      = S_EMIT;
                end else begin
                    w_wr_data = r_rd_data;
                    n_pos     = r_pos - AW'(1);
                    n_state   = S_INS_RD;
                end
            end
            S_DEQ: begin
                n_res_status = spq_pkg::ST_OK;
                n_res_value  = r_rd_data[EW-1:PB];
                n_res_prio   = w_rd_prio;
                n_head       = f_wrap_add(r_head, AW'(1));
                n_count      = r_count - CW'(1);
                n_state      = S_EMIT;
            end
            S_EMIT: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign w_out_prio_ext = {{spq_pkg::OUT_PRIO_W{1'b0}}, r_res_prio};
    assign w_fill_ext     = {{spq_pkg::FILL_W{1'b0}}, r_count};

    always_comb begin
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        if (r_out_valid && i_m_tready) begin
            n_out_valid = 1'b0;
        end
        if (r_state == S_EMIT && w_out_free) begin
            n_out_valid = 1'b1;
            n_out_data  = {
                1'b0,
                w_fill_ext[spq_pkg::FILL_W-1:0],
                w_out_prio_ext[spq_pkg::OUT_PRIO_W-1:0],
                r_res_value,
                r_res_status
            };
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos        <= n_pos;
        r_new_value  <= n_new_value;
        r_new_prio   <= n_new_prio;
        r_res_status <= n_res_status;
        r_res_value  <= n_res_value;
        r_res_prio   <= n_res_prio;
        r_out_data   <= n_out_data;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

endmodule
